// ----- design/wts_pkg.sv -----
package wts_pkg;

   localparam int PHASE_BITS        = 12;
   localparam int REQ_DATA_BITS     = 16;
   localparam int WAVE_MODE_BITS    = 3;
   localparam int SIZE_LOG2_BITS    = 4;
   localparam int CSR_DATA_BITS     = 4;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int DEF_MAX_SIZE_BITS = 12;
   localparam int DEF_SAMPLE_BITS   = 16;
   localparam int MIN_SIZE_LOG2     = 5;

   localparam logic [SIZE_LOG2_BITS-1:0] SIZE_LOG2_RESET = SIZE_LOG2_BITS'(9);

   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVE_MODE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIZE_LOG2 = CSR_INDEX_BITS'(1);

   typedef enum logic [WAVE_MODE_BITS-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_TRIANGLE = 3'd2,
      WAVE_SAW_UP   = 3'd3,
      WAVE_SAW_DOWN = 3'd4
   } wave_type;

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

   // quarter-wave sine at r / 2^qb of a quarter turn, rounded to frac bits, saturated
   function automatic longint unsigned sine_entry(input longint unsigned r,
                                                  input int unsigned qb,
                                                  input int unsigned frac);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      longint unsigned v;
      longint unsigned vmax;
      int n;
      x  = (HALF_PI_Q30 * r) >> qb;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (n = 0; n < 6; n++) begin
         t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[n]);
      end
      y    = (x * t) >> 30;
      v    = (y + (64'd1 << (29 - frac))) >> (30 - frac);
      vmax = (64'd1 << frac) - 64'd1;
      if (v > vmax) begin
         v = vmax;
      end
      return v;
   endfunction

endpackage

// ----- design/wts_sine_rom.sv -----
module wts_sine_rom #(
   parameter int MAX_SIZE_BITS = wts_pkg::DEF_MAX_SIZE_BITS,
   parameter int SAMPLE_BITS   = wts_pkg::DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [MAX_SIZE_BITS-2:0] rd_addr,
   output logic [SAMPLE_BITS-1:0]   rd_data
);
   import wts_pkg::*;

   localparam int QB        = MAX_SIZE_BITS - 2;
   localparam int ROM_DEPTH = (1 << QB) + 1;

   typedef logic [SAMPLE_BITS-1:0] rom_type [ROM_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      int a;
      for (a = 0; a < ROM_DEPTH; a++) begin
         rom[a] = SAMPLE_BITS'(sine_entry(64'(a), QB, SAMPLE_BITS - 1));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/wts_ramp.sv -----
module wts_ramp #(
   parameter int MAX_SIZE_BITS = wts_pkg::DEF_MAX_SIZE_BITS,
   parameter int SAMPLE_BITS   = wts_pkg::DEF_SAMPLE_BITS
) (
   input  logic [MAX_SIZE_BITS-1:0]             pos,
   input  logic [wts_pkg::WAVE_MODE_BITS-1:0]   mode,
   output logic [SAMPLE_BITS-1:0]               value
);
   import wts_pkg::*;

   localparam int M    = MAX_SIZE_BITS;
   localparam int FRAC = SAMPLE_BITS - 1;
   localparam int KW   = M + 3;
   localparam int SW   = M + FRAC + 2;

   localparam longint SQ_RAW  = (((64'sd1 << FRAC) * 999999) + 500000) / 1000000;
   localparam longint SQ_MAXV = (64'sd1 << FRAC) - 1;
   localparam logic [SAMPLE_BITS-1:0] SQ_LEVEL =
      SAMPLE_BITS'((SQ_RAW > SQ_MAXV) ? SQ_MAXV : SQ_RAW);
   localparam logic [SAMPLE_BITS-1:0] POS_MAX = SAMPLE_BITS'(SQ_MAXV);

   localparam logic signed [KW-1:0] K_ONE  = KW'(1) << M;
   localparam logic signed [KW-1:0] K_HALF = KW'(1) << (M - 1);

   logic signed [KW-1:0]   u_ext;
   logic signed [KW-1:0]   k;
   logic                   k_neg;
   logic [M:0]             mag;
   logic [SW-1:0]          scaled;
   logic [SAMPLE_BITS-1:0] rat;
   logic [SAMPLE_BITS-1:0] ratio_val;

   always_comb begin
      u_ext = signed'(KW'(pos));
      case (mode)
         WAVE_TRIANGLE: k = pos[M-1] ? ((u_ext - K_HALF) <<< 2) - K_ONE
                                     : K_ONE - (u_ext <<< 2);
         WAVE_SAW_UP:   k = (u_ext <<< 1) - K_ONE;
         WAVE_SAW_DOWN: k = K_ONE - (u_ext <<< 1);
         default:       k = '0;
      endcase
      k_neg  = k[KW-1];
      mag    = k_neg ? (M+1)'(-k) : (M+1)'(k);
      scaled = (SW'(mag) << FRAC) + (SW'(1) << (M - 1));
      rat    = scaled[M+FRAC:M];
      if (k_neg) begin
         ratio_val = -rat;
      end else if (rat[FRAC]) begin
         ratio_val = POS_MAX;
      end else begin
         ratio_val = rat;
      end
      case (mode) inside
         WAVE_SQUARE:                              value = pos[M-1] ? -SQ_LEVEL : SQ_LEVEL;
         WAVE_TRIANGLE, WAVE_SAW_UP, WAVE_SAW_DOWN: value = ratio_val;
         default:                                  value = '0;
      endcase
   end

endmodule

// ----- design/wavetable_waveform_sample.sv -----
// Wavetable waveform sample generator.
// req channel: one table index per transfer (req_tdata[11:0] = phase_index).
// rsp channel: one sample per accepted index, in order (rsp_tdata low SAMPLE_BITS
// bits, two's complement, Q1.(SAMPLE_BITS-1)).
// csr port: csr_index 0 writes wave_mode (0 sine, 1 square, 2 triangle,
// 3 rising saw, 4 falling saw, others give 0); csr_index 1 writes size_log2,
// clamped to 5..MAX_SIZE_BITS. Write only while no transfer is in flight.
// Each index is registered in the ROM stage, then in the rsp register. Throughput:
// one index per cycle unless rsp stalls, set by the single-port quarter-wave sine
// ROM with a registered read; ramps and square are formed alongside the read.
// The sine ROM is shared by all table sizes by scaling the index to the
// largest table; its contents are fixed at elaboration, so no fill is needed.
// Reset: clears both pipeline valid flags and sets wave_mode 0, size_log2 9.
// Stall: when rsp_tready is low with a sample held, the whole pipeline holds
// and req_tready drops; one held sample and one in the ROM stage are kept.
module wavetable_waveform_sample #(
   parameter int MAX_SIZE_BITS = wts_pkg::DEF_MAX_SIZE_BITS,
   parameter int SAMPLE_BITS   = wts_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [wts_pkg::REQ_DATA_BITS-1:0]     req_tdata,   // [11:0] phase_index
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                                  csr_wen,
   input  logic [wts_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wts_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import wts_pkg::*;

   localparam int M     = MAX_SIZE_BITS;
   localparam int RSP_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SZW   = $clog2(M + 1);
   localparam int UW    = M + PHASE_BITS;
   localparam int AW    = M - 1;

   logic [WAVE_MODE_BITS-1:0] mode_ff, mode_in;
   logic [SIZE_LOG2_BITS-1:0] size_ff, size_in;

   logic                   s1_vld_ff, s1_vld_in;
   logic                   s1_neg_ff;
   logic                   s1_sine_ff;
   logic [SAMPLE_BITS-1:0] s1_ramp_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                   advance;
   logic [SZW-1:0]         size_eff;
   logic [SZW-1:0]         shift_amt;
   logic [UW-1:0]          u_wide;
   logic [M-1:0]           pos;
   logic [1:0]             quad;
   logic [AW-1:0]          rom_addr;
   logic [SAMPLE_BITS-1:0] rom_data;
   logic [SAMPLE_BITS-1:0] ramp_val;
   logic [SAMPLE_BITS-1:0] sine_val;

   always_comb begin
      mode_in = mode_ff;
      size_in = size_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_WAVE_MODE: mode_in = csr_wdata[WAVE_MODE_BITS-1:0];
            REG_SIZE_LOG2: size_in = csr_wdata[SIZE_LOG2_BITS-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= WAVE_SINE;
         size_ff <= SIZE_LOG2_RESET;
      end else begin
         mode_ff <= mode_in;
         size_ff <= size_in;
      end
   end

   // scale the index up to the largest table: high index bits fall off the top
   always_comb begin
      if (SZW'(size_ff) < SZW'(MIN_SIZE_LOG2)) begin
         size_eff = SZW'(MIN_SIZE_LOG2);
      end else if (SZW'(size_ff) > SZW'(M)) begin
         size_eff = SZW'(M);
      end else begin
         size_eff = SZW'(size_ff);
      end
      shift_amt = SZW'(M) - size_eff;
      u_wide    = UW'(req_tdata[PHASE_BITS-1:0]) << shift_amt;
      pos       = u_wide[M-1:0];
      quad      = pos[M-1:M-2];
      rom_addr  = quad[0] ? (AW'(1) << (M - 2)) - AW'(pos[M-3:0]) : AW'(pos[M-3:0]);
   end

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;

   wts_sine_rom #(
      .MAX_SIZE_BITS (MAX_SIZE_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (advance),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   wts_ramp #(
      .MAX_SIZE_BITS (MAX_SIZE_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_ramp (
      .pos   (pos),
      .mode  (mode_ff),
      .value (ramp_val)
   );

   always_comb begin
      sine_val    = s1_neg_ff ? -rom_data : rom_data;
      s1_vld_in   = advance ? req_tvalid : s1_vld_ff;
      rsp_vld_in  = advance ? s1_vld_ff : rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in = s1_sine_ff ? sine_val : s1_ramp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_ff  <= quad[1];
         s1_sine_ff <= (mode_ff == WAVE_SINE);
         s1_ramp_ff <= ramp_val;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
